FILE: design/dns_record_name_encoder_core_macros.svh
// Assertion macros for the DNS record name encoder modules.
`ifndef DNS_RECORD_NAME_ENCODER_CORE_MACROS_SVH
`define DNS_RECORD_NAME_ENCODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DNSENC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DNSENC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dnsenc_pkg.sv
// Types, constants and helper functions of the DNS record name encoder.
package dnsenc_pkg;

  localparam int LABEL_MAX_DEFAULT = 48;

  localparam logic [7:0] SEPARATOR = 8'h2E;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WITH_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_TYPE   = 2'd2;

  // Output byte sources.
  localparam logic [1:0] EMIT_LEN   = 2'd0;
  localparam logic [1:0] EMIT_LABEL = 2'd1;
  localparam logic [1:0] EMIT_ZERO  = 2'd2;
  localparam logic [1:0] EMIT_TRAIL = 2'd3;

  // Fixed record fields.
  localparam logic [7:0] TYPE_A     = 8'd1;
  localparam logic [7:0] CLASS_IN   = 8'd1;
  localparam logic [7:0] ADDR_TTL   = 8'd120;
  localparam logic [7:0] ADDR_RDLEN = 8'd4;

  localparam int TRAIL_W = 4;
  localparam logic [TRAIL_W-1:0] TRAIL_LAST_ADDR  = 4'd13;
  localparam logic [TRAIL_W-1:0] TRAIL_LAST_OTHER = 4'd9;

  typedef struct packed {
    logic       take;
    logic       emit;
    logic [1:0] emit_sel;
    logic       idx_clr;
    logic       idx_inc;
    logic       len_clr;
    logic       tidx_clr;
    logic       tidx_inc;
    logic       rec_done;
  } dnsenc_cmd_t;

  typedef struct packed {
    logic in_dot;
    logic in_last;
    logic out_free;
    logic len_zero;
    logic idx_last;
    logic trail_last;
    logic last_r;
  } dnsenc_status_t;

  // Byte k of the part of the record that follows the name's zero byte.
  function automatic logic [7:0] trailer_byte(input logic                with_addr,
                                              input logic [TRAIL_W-1:0]  k,
                                              input logic [31:0]         addr,
                                              input logic [15:0]         typ);
    logic [7:0] b;
    b = 8'd0;
    if (with_addr) begin
      case (k)
        4'd1:    b = TYPE_A;
        4'd3:    b = CLASS_IN;
        4'd7:    b = ADDR_TTL;
        4'd9:    b = ADDR_RDLEN;
        4'd10:   b = addr[31:24];
        4'd11:   b = addr[23:16];
        4'd12:   b = addr[15:8];
        4'd13:   b = addr[7:0];
        default: b = 8'd0;
      endcase
    end else begin
      case (k)
        4'd0:    b = typ[15:8];
        4'd1:    b = typ[7:0];
        4'd3:    b = CLASS_IN;
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

endpackage

FILE: design/dnsenc_ram.sv
// Generic memory with one write port and one registered read port.
module dnsenc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/dnsenc_dp.sv
// Datapath: label memory, counters, configuration registers and output register.
module dnsenc_dp import dnsenc_pkg::*; #(
  parameter int LABEL_MAX = LABEL_MAX_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dnsenc_cmd_t          cmd,
  output dnsenc_status_t       st,
  input  logic [7:0]           ch,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 end_of_record,
  output logic                 overflow,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int LW = $clog2(LABEL_MAX + 1);

  logic [LW-1:0]      len;
  logic [LW-1:0]      idx;
  logic [TRAIL_W-1:0] tidx;
  logic               dropped;
  logic               last_r;
  logic               with_address;
  logic [31:0]        address;
  logic [15:0]        other_type_code;
  logic               in_dot;
  logic               room;
  logic               store_we;
  logic [7:0]         rd_data;
  logic [7:0]         emit_byte;

  assign in_dot   = (ch == SEPARATOR);
  assign room     = (len < LW'(LABEL_MAX));
  assign store_we = cmd.take && !in_dot && room;

  dnsenc_ram #(
    .WIDTH(8),
    .DEPTH(LABEL_MAX)
  ) u_label_ram (
    .clk  (clk),
    .we   (store_we),
    .waddr(len[AW-1:0]),
    .wdata(ch),
    .raddr(idx[AW-1:0]),
    .rdata(rd_data)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      with_address    <= 1'b1;
      address         <= 32'd0;
      other_type_code <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WITH_ADDRESS: with_address    <= cfg_data[0];
        CFG_ADDRESS:      address         <= cfg_data;
        CFG_OTHER_TYPE:   other_type_code <= cfg_data[15:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      idx     <= '0;
      tidx    <= '0;
      dropped <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      if (cmd.take) begin
        last_r <= last;
        if (store_we) begin
          len <= len + LW'(1);
        end else if (!in_dot) begin
          dropped <= 1'b1;
        end
      end
      if (cmd.len_clr) begin
        len <= '0;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + LW'(1);
      end
      if (cmd.tidx_clr) begin
        tidx <= '0;
      end else if (cmd.tidx_inc) begin
        tidx <= tidx + TRAIL_W'(1);
      end
      if (cmd.rec_done) begin
        dropped <= 1'b0;
      end
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      EMIT_LEN:   emit_byte = 8'(len);
      EMIT_LABEL: emit_byte = rd_data;
      EMIT_ZERO:  emit_byte = 8'd0;
      EMIT_TRAIL: emit_byte = trailer_byte(with_address, tidx, address, other_type_code);
      default:    emit_byte = 8'd0;
    endcase
  end

  // The output register frees as soon as its byte is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte      <= emit_byte;
      end_of_record <= cmd.rec_done;
      overflow      <= dropped;
    end
  end

  assign st.in_dot     = in_dot;
  assign st.in_last    = last;
  assign st.out_free   = !out_valid || out_ready;
  assign st.len_zero   = (len == '0);
  assign st.idx_last   = ((idx + LW'(1)) == len);
  assign st.trail_last = with_address ? (tidx == TRAIL_LAST_ADDR) : (tidx == TRAIL_LAST_OTHER);
  assign st.last_r     = last_r;

endmodule

FILE: design/dnsenc_ctrl.sv
// Controller state machine that sequences label flushes and the record trailer.
`include "dns_record_name_encoder_core_macros.svh"

module dnsenc_ctrl import dnsenc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dnsenc_status_t st,
  output dnsenc_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEN   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_BYTE  = 3'd3;
  localparam logic [2:0] S_ZERO  = 3'd4;
  localparam logic [2:0] S_TRAIL = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          // A non-dot last character always leaves a non-empty label to flush.
          if (st.in_dot || st.in_last) begin
            state_next = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_LEN;
          cmd.idx_clr  = 1'b1;
          if (st.len_zero) begin
            cmd.len_clr = 1'b1;
            state_next  = st.last_r ? S_ZERO : S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        state_next = S_BYTE;
      end
      S_BYTE: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_LABEL;
          cmd.idx_inc  = 1'b1;
          if (st.idx_last) begin
            cmd.len_clr = 1'b1;
            state_next  = st.last_r ? S_ZERO : S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_ZERO: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_ZERO;
          cmd.tidx_clr = 1'b1;
          state_next   = S_TRAIL;
        end
      end
      S_TRAIL: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_TRAIL;
          cmd.tidx_inc = 1'b1;
          if (st.trail_last) begin
            cmd.rec_done = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `DNSENC_ASSERT_NEXT(a_dot_flushes, clk, rst, cmd.take && st.in_dot, state == S_LEN, "dot did not start a label flush")
  `DNSENC_ASSERT_NEXT(a_len_cleared, clk, rst, cmd.len_clr, st.len_zero, "label length not cleared after flush")
  `DNSENC_ASSERT_NEXT(a_record_closes, clk, rst, cmd.rec_done, (state == S_IDLE) && st.len_zero, "record end left pending state")

endmodule

FILE: design/dns_record_name_encoder_core.sv
// Top level of the DNS record name encoder: controller plus datapath.
//
// Usage: domain name characters arrive one per transfer on the input channel
// (ch, last). Each transfer of a dot, and the transfer marked last, yields
// wire bytes on the output channel (out_byte, end_of_record, overflow); the
// record's final byte carries end_of_record. The configuration channel
// (cfg_index, cfg_data) is always ready and must only be used while idle.
// Sequence: an ordinary character is stored while the label has room. A dot
// emits the label's length byte, then each label byte, each first read
// through the registered read port of the label memory. The last character
// then adds the zero byte and 14 trailer bytes in address mode, 10 otherwise.
// A single output register separates the channels: when the receiver stalls,
// the controller holds in its current state until the register frees, and a
// plain character is still accepted while an earlier byte waits.
// Reset clears the label length, drop flag, output valid and the state
// machine, and restores the configuration defaults; no memory clearing pass.
module dns_record_name_encoder_core import dnsenc_pkg::*; #(
  parameter int LABEL_MAX = LABEL_MAX_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           ch,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 end_of_record,
  output logic                 overflow,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dnsenc_cmd_t    cmd;
  dnsenc_status_t st;

  // The controller decides which byte goes out next; it never touches data.
  dnsenc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  // The datapath stores the label, holds configuration and the output register.
  dnsenc_dp #(
    .LABEL_MAX(LABEL_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .ch           (ch),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .end_of_record(end_of_record),
    .overflow     (overflow),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule
